// ----- design/slx_pkg.sv -----
// Shared types, token class codes and the keyword table of the source line lexer.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package slx_pkg;

    localparam int COLUMN_BITS_DEFAULT = 16;
    localparam int KEYWORD_COUNT       = 40;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int WORD_CHARS          = 8;

    // Token classes
    localparam logic [5:0] C_EOL     = 6'd0;
    localparam logic [5:0] C_ERR     = 6'd1;
    localparam logic [5:0] C_IDENT   = 6'd2;
    localparam logic [5:0] C_KEYWORD = 6'd3;
    localparam logic [5:0] C_INT     = 6'd4;
    localparam logic [5:0] C_FLOAT   = 6'd5;
    localparam logic [5:0] C_STR     = 6'd6;
    localparam logic [5:0] C_FSTR    = 6'd7;
    localparam logic [5:0] C_RSTR    = 6'd8;
    localparam logic [5:0] C_CHAR    = 6'd9;
    localparam logic [5:0] C_SPACE   = 6'd10;
    localparam logic [5:0] C_LCOM    = 6'd11;
    localparam logic [5:0] C_BCOM    = 6'd12;
    localparam logic [5:0] C_UNDER   = 6'd13;
    localparam logic [5:0] O_EQ      = 6'd14;
    localparam logic [5:0] O_EQ2     = 6'd15;
    localparam logic [5:0] O_PLUS    = 6'd16;
    localparam logic [5:0] O_PLUSEQ  = 6'd17;
    localparam logic [5:0] O_INC     = 6'd18;
    localparam logic [5:0] O_MINUS   = 6'd19;
    localparam logic [5:0] O_MINUSEQ = 6'd20;
    localparam logic [5:0] O_DEC     = 6'd21;
    localparam logic [5:0] O_STAR    = 6'd22;
    localparam logic [5:0] O_STAREQ  = 6'd23;
    localparam logic [5:0] O_SLASH   = 6'd24;
    localparam logic [5:0] O_SLASHEQ = 6'd25;
    localparam logic [5:0] O_LT      = 6'd26;
    localparam logic [5:0] O_LE      = 6'd27;
    localparam logic [5:0] O_SHL     = 6'd28;
    localparam logic [5:0] O_SHLEQ   = 6'd29;
    localparam logic [5:0] O_GT      = 6'd30;
    localparam logic [5:0] O_GE      = 6'd31;
    localparam logic [5:0] O_SHR     = 6'd32;
    localparam logic [5:0] O_SHREQ   = 6'd33;
    localparam logic [5:0] O_AMP     = 6'd34;
    localparam logic [5:0] O_AMP2    = 6'd35;
    localparam logic [5:0] O_AMPEQ   = 6'd36;
    localparam logic [5:0] O_BAR     = 6'd37;
    localparam logic [5:0] O_BAR2    = 6'd38;
    localparam logic [5:0] O_BAREQ   = 6'd39;
    localparam logic [5:0] O_BANG    = 6'd40;
    localparam logic [5:0] O_NE      = 6'd41;
    localparam logic [5:0] O_PCT     = 6'd42;
    localparam logic [5:0] O_PCTEQ   = 6'd43;
    localparam logic [5:0] O_DOT     = 6'd44;
    localparam logic [5:0] O_COMMA   = 6'd45;
    localparam logic [5:0] O_COLON   = 6'd46;
    localparam logic [5:0] O_SEMI    = 6'd47;
    localparam logic [5:0] O_QUEST   = 6'd48;
    localparam logic [5:0] O_LPAR    = 6'd49;
    localparam logic [5:0] O_RPAR    = 6'd50;
    localparam logic [5:0] O_LSQB    = 6'd51;
    localparam logic [5:0] O_RSQB    = 6'd52;
    localparam logic [5:0] O_LBRACE  = 6'd53;
    localparam logic [5:0] O_RBRACE  = 6'd54;
    localparam logic [5:0] O_TILDE   = 6'd55;
    localparam logic [5:0] O_CARET   = 6'd56;
    localparam logic [5:0] O_CARETEQ = 6'd57;
    localparam logic [5:0] O_AT      = 6'd58;
    localparam logic [5:0] O_HASH    = 6'd59;

    // Keywords, right-aligned: the last character sits in the low byte,
    // which is the order in which the scanner shifts a word in.
    localparam logic [63:0] KEYWORDS [KEYWORD_COUNT] = '{
        64'("if"), 64'("for"), 64'("int"), 64'("let"), 64'("try"), 64'("use"),
        64'("var"), 64'("base"), 64'("bool"), 64'("case"), 64'("char"),
        64'("elif"), 64'("else"), 64'("enum"), 64'("func"), 64'("long"),
        64'("null"), 64'("self"), 64'("true"), 64'("uint"), 64'("async"),
        64'("await"), 64'("break"), 64'("catch"), 64'("class"), 64'("const"),
        64'("false"), 64'("float"), 64'("short"), 64'("throw"), 64'("ulong"),
        64'("while"), 64'("double"), 64'("object"), 64'("return"),
        64'("string"), 64'("struct"), 64'("switch"), 64'("ushort"),
        64'("continue")
    };

    typedef struct packed {
        logic [7:0]  character;
        logic        end_of_line;
        logic [15:0] line_number;
    } char_item_t;

    typedef struct packed {
        logic [5:0]  token_class;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic [15:0] token_line;
        logic        last_of_run;
    } token_item_t;

    // One queue entry: the requests caused by one character item.
    typedef struct packed {
        logic [5:0]  token_class;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic [15:0] token_line;
        logic [63:0] word;
        logic [3:0]  word_length;
        logic        eol_follows;
        logic [15:0] eol_column;
    } entry_t;

    // Parallel compare against the whole keyword table.
    function automatic logic keyword_hit(input logic [63:0] word, input logic [3:0] wlen);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            if (word == KEYWORDS[k])
                hit = 1'b1;
        end
        return hit && (wlen >= 4'd2) && (wlen <= 4'd8);
    endfunction

endpackage

`default_nettype wire

// ----- design/slx_front.sv -----
// Scanner front end: accepts characters, tracks the pending token and pushes
// finished token requests into the queue. Depends on slx_pkg.
`default_nettype none

module slx_front #(
    parameter int COLUMN_BITS = slx_pkg::COLUMN_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire slx_pkg::char_item_t item,
    input  wire logic                cfg_write,
    input  wire logic [15:0]         cfg_data,
    output logic                     push,
    output slx_pkg::entry_t          entry
);

    localparam logic [3:0] M_LSTART = 4'd0;
    localparam logic [3:0] M_IDLE   = 4'd1;
    localparam logic [3:0] M_CLOSED = 4'd2;
    localparam logic [3:0] M_OPER   = 4'd3;
    localparam logic [3:0] M_WORD   = 4'd4;
    localparam logic [3:0] M_NUMBER = 4'd5;
    localparam logic [3:0] M_SPACE  = 4'd6;
    localparam logic [3:0] M_QUOTED = 4'd7;
    localparam logic [3:0] M_RAW    = 4'd8;
    localparam logic [3:0] M_LCOM   = 4'd9;
    localparam logic [3:0] M_BCOM   = 4'd10;

    logic [3:0]             mode_reg, mode_next;
    logic [5:0]             class_reg, class_next;
    logic [15:0]            start_reg, start_next;
    logic [15:0]            length_reg, length_next;
    logic [63:0]            word_reg, word_next;
    logic [3:0]             wlen_reg, wlen_next;
    logic                   escape_reg, escape_next;
    logic                   star_reg, star_next;
    logic                   copen_reg, copen_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic [15:0]            line_start_reg;

    logic [15:0] col16;
    logic [7:0]  c;
    logic [5:0]  b_class;
    logic [3:0]  b_mode;
    logic        b_word;
    logic        is_digit;
    logic        is_alpha;

    assign col16 = 16'(column_reg);
    assign c     = item.character;
    assign is_digit = (c >= "0") && (c <= "9");
    assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));

    // Class and mode of a token opened by the current character
    always_comb
    begin
        b_mode  = M_CLOSED;
        b_word  = 1'b0;
        b_class = slx_pkg::C_ERR;
        unique case (c)
            "=":  begin b_class = slx_pkg::O_EQ;    b_mode = M_OPER; end
            "+":  begin b_class = slx_pkg::O_PLUS;  b_mode = M_OPER; end
            "-":  begin b_class = slx_pkg::O_MINUS; b_mode = M_OPER; end
            "*":  begin b_class = slx_pkg::O_STAR;  b_mode = M_OPER; end
            "/":  begin b_class = slx_pkg::O_SLASH; b_mode = M_OPER; end
            "<":  begin b_class = slx_pkg::O_LT;    b_mode = M_OPER; end
            ">":  begin b_class = slx_pkg::O_GT;    b_mode = M_OPER; end
            "&":  begin b_class = slx_pkg::O_AMP;   b_mode = M_OPER; end
            "|":  begin b_class = slx_pkg::O_BAR;   b_mode = M_OPER; end
            "!":  begin b_class = slx_pkg::O_BANG;  b_mode = M_OPER; end
            "%":  begin b_class = slx_pkg::O_PCT;   b_mode = M_OPER; end
            "^":  begin b_class = slx_pkg::O_CARET; b_mode = M_OPER; end
            ".":  b_class = slx_pkg::O_DOT;
            ",":  b_class = slx_pkg::O_COMMA;
            ":":  b_class = slx_pkg::O_COLON;
            ";":  b_class = slx_pkg::O_SEMI;
            "?":  b_class = slx_pkg::O_QUEST;
            "(":  b_class = slx_pkg::O_LPAR;
            ")":  b_class = slx_pkg::O_RPAR;
            "[":  b_class = slx_pkg::O_LSQB;
            "]":  b_class = slx_pkg::O_RSQB;
            "{":  b_class = slx_pkg::O_LBRACE;
            "}":  b_class = slx_pkg::O_RBRACE;
            "~":  b_class = slx_pkg::O_TILDE;
            "@":  b_class = slx_pkg::O_AT;
            "#":  b_class = slx_pkg::O_HASH;
            " ":  begin b_class = slx_pkg::C_SPACE; b_mode = M_SPACE; end
            "'":  begin b_class = slx_pkg::C_CHAR;  b_mode = M_QUOTED; end
            "\"": begin b_class = slx_pkg::C_STR;   b_mode = M_QUOTED; end
            "_":
            begin
                b_class = slx_pkg::C_UNDER;
                b_mode  = M_WORD;
                b_word  = 1'b1;
            end
            default:
            begin
                if (is_digit)
                begin
                    b_class = slx_pkg::C_INT;
                    b_mode  = M_NUMBER;
                end
                else if (is_alpha)
                begin
                    b_class = slx_pkg::C_IDENT;
                    b_mode  = M_WORD;
                    b_word  = 1'b1;
                end
            end
        endcase
    end

    // Scanner step: extend the pending token or close it and open a new one
    always_comb
    begin
        logic        ok;
        logic        opening;
        logic        more;
        logic [5:0]  op_next;

        mode_next   = mode_reg;
        class_next  = class_reg;
        start_next  = start_reg;
        length_next = length_reg;
        word_next   = word_reg;
        wlen_next   = wlen_reg;
        escape_next = escape_reg;
        star_next   = star_reg;
        copen_next  = copen_reg;
        column_next = column_reg;
        push        = 1'b0;
        entry       = '0;
        ok          = 1'b0;
        opening     = 1'b0;
        more        = 1'b0;
        op_next     = slx_pkg::C_EOL;
        entry.token_line = item.line_number;

        if (accept && item.end_of_line)
        begin
            push = 1'b1;
            if ((mode_reg != M_IDLE) && (mode_reg != M_LSTART))
            begin
                entry.token_class  = class_reg;
                entry.start_column = start_reg;
                entry.token_length = length_reg;
                entry.word         = word_reg;
                entry.word_length  = wlen_reg;
                entry.eol_follows  = 1'b1;
                entry.eol_column   = col16;
            end
            else
            begin
                entry.token_class  = slx_pkg::C_EOL;
                entry.start_column = col16;
            end
            mode_next   = M_LSTART;
            column_next = COLUMN_BITS'(line_start_reg);
            start_next  = '0;
            length_next = '0;
            word_next   = '0;
            wlen_next   = '0;
            escape_next = 1'b0;
            star_next   = 1'b0;
        end
        else if (accept)
        begin
            // First character of a line: maybe resume an open block comment
            if (mode_next == M_LSTART)
            begin
                mode_next = M_IDLE;
                if (copen_reg && (column_reg == '0))
                begin
                    mode_next   = M_BCOM;
                    class_next  = slx_pkg::C_BCOM;
                    start_next  = '0;
                    length_next = '0;
                    star_next   = 1'b0;
                end
            end

            if (mode_next == M_IDLE)
                opening = 1'b1;
            else
            begin
                unique case (mode_next)
                    M_OPER:
                    begin
                        case (class_next)
                            slx_pkg::O_EQ:
                                if (c == "=") op_next = slx_pkg::O_EQ2;
                            slx_pkg::O_PLUS:
                                if (c == "=") op_next = slx_pkg::O_PLUSEQ;
                                else if (c == "+") op_next = slx_pkg::O_INC;
                            slx_pkg::O_MINUS:
                                if (c == "=") op_next = slx_pkg::O_MINUSEQ;
                                else if (c == "-") op_next = slx_pkg::O_DEC;
                            slx_pkg::O_STAR:
                                if (c == "=") op_next = slx_pkg::O_STAREQ;
                            slx_pkg::O_SLASH:
                                if (c == "=") op_next = slx_pkg::O_SLASHEQ;
                            slx_pkg::O_LT:
                                if (c == "=") op_next = slx_pkg::O_LE;
                                else if (c == "<")
                                begin
                                    op_next = slx_pkg::O_SHL;
                                    more    = 1'b1;
                                end
                            slx_pkg::O_SHL:
                                if (c == "=") op_next = slx_pkg::O_SHLEQ;
                            slx_pkg::O_GT:
                                if (c == "=") op_next = slx_pkg::O_GE;
                                else if (c == ">")
                                begin
                                    op_next = slx_pkg::O_SHR;
                                    more    = 1'b1;
                                end
                            slx_pkg::O_SHR:
                                if (c == "=") op_next = slx_pkg::O_SHREQ;
                            slx_pkg::O_AMP:
                                if (c == "&") op_next = slx_pkg::O_AMP2;
                                else if (c == "=") op_next = slx_pkg::O_AMPEQ;
                            slx_pkg::O_BAR:
                                if (c == "|") op_next = slx_pkg::O_BAR2;
                                else if (c == "=") op_next = slx_pkg::O_BAREQ;
                            slx_pkg::O_BANG:
                                if (c == "=") op_next = slx_pkg::O_NE;
                            slx_pkg::O_PCT:
                                if (c == "=") op_next = slx_pkg::O_PCTEQ;
                            slx_pkg::O_CARET:
                                if (c == "=") op_next = slx_pkg::O_CARETEQ;
                            default: op_next = slx_pkg::C_EOL;
                        endcase
                        if ((class_next == slx_pkg::O_SLASH) && (c == "/"))
                        begin
                            ok         = 1'b1;
                            class_next = slx_pkg::C_LCOM;
                            mode_next  = M_LCOM;
                        end
                        else if ((class_next == slx_pkg::O_SLASH) && (c == "*"))
                        begin
                            ok         = 1'b1;
                            class_next = slx_pkg::C_BCOM;
                            mode_next  = M_BCOM;
                            copen_next = 1'b1;
                            star_next  = 1'b0;
                        end
                        else if (op_next != slx_pkg::C_EOL)
                        begin
                            ok         = 1'b1;
                            class_next = op_next;
                            mode_next  = more ? M_OPER : M_CLOSED;
                        end
                    end
                    M_WORD:
                    begin
                        if (is_digit || is_alpha || (c == "_"))
                        begin
                            ok         = 1'b1;
                            class_next = slx_pkg::C_IDENT;
                            if (wlen_reg < 4'd8)
                            begin
                                word_next = {word_reg[55:0], c};
                                wlen_next = wlen_reg + 4'd1;
                            end
                            else
                                wlen_next = 4'd9;
                        end
                        else if ((c == "\"") && (class_reg == slx_pkg::C_IDENT)
                                 && (wlen_reg == 4'd1)
                                 && ((word_reg == 64'("f")) || (word_reg == 64'("r"))))
                        begin
                            // Prefixed string: the quote follows the letter directly
                            ok          = 1'b1;
                            escape_next = 1'b0;
                            if (word_reg == 64'("f"))
                            begin
                                class_next = slx_pkg::C_FSTR;
                                mode_next  = M_QUOTED;
                            end
                            else
                            begin
                                class_next = slx_pkg::C_RSTR;
                                mode_next  = M_RAW;
                            end
                        end
                    end
                    M_NUMBER:
                    begin
                        if (is_digit)
                            ok = 1'b1;
                        else if ((c == ".") && (class_reg == slx_pkg::C_INT))
                        begin
                            ok         = 1'b1;
                            class_next = slx_pkg::C_FLOAT;
                        end
                    end
                    M_SPACE:
                        ok = (c == " ");
                    M_QUOTED:
                    begin
                        ok = 1'b1;
                        if (escape_reg)
                            escape_next = 1'b0;
                        else if (c == "\\")
                            escape_next = 1'b1;
                        else if (c == ((class_reg == slx_pkg::C_CHAR) ? "'" : "\""))
                            mode_next = M_CLOSED;
                    end
                    M_RAW:
                    begin
                        ok = 1'b1;
                        if (c == "\"")
                            mode_next = M_CLOSED;
                    end
                    M_LCOM:
                        ok = 1'b1;
                    M_BCOM:
                    begin
                        ok = 1'b1;
                        if (star_next && (c == "/"))
                        begin
                            mode_next  = M_CLOSED;
                            copen_next = 1'b0;
                            star_next  = 1'b0;
                        end
                        else
                            star_next = (c == "*");
                    end
                    default:
                        ok = 1'b0;
                endcase

                if (ok)
                begin
                    if (length_next != 16'hFFFF)
                        length_next = length_next + 16'd1;
                end
                else
                begin
                    // Token ends here: send it on and open the next one
                    push               = 1'b1;
                    entry.token_class  = class_reg;
                    entry.start_column = start_next;
                    entry.token_length = length_next;
                    entry.word         = word_reg;
                    entry.word_length  = wlen_reg;
                    opening            = 1'b1;
                end
            end

            if (opening)
            begin
                start_next  = col16;
                length_next = 16'd1;
                escape_next = 1'b0;
                class_next  = b_class;
                mode_next   = b_mode;
                word_next   = b_word ? {56'd0, c} : 64'd0;
                wlen_next   = b_word ? 4'd1 : 4'd0;
            end
            column_next = column_reg + 1'b1;
        end
    end

    // Line start column register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_start_reg <= '0;
        else if (cfg_write)
            line_start_reg <= cfg_data;
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_LSTART;
            class_reg  <= slx_pkg::C_EOL;
            start_reg  <= '0;
            length_reg <= '0;
            word_reg   <= '0;
            wlen_reg   <= '0;
            escape_reg <= 1'b0;
            star_reg   <= 1'b0;
            copen_reg  <= 1'b0;
            column_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            class_reg  <= class_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            word_reg   <= word_next;
            wlen_reg   <= wlen_next;
            escape_reg <= escape_next;
            star_reg   <= star_next;
            copen_reg  <= copen_next;
            if (cfg_write && (mode_reg == M_LSTART))
                column_reg <= COLUMN_BITS'(cfg_data);
            else
                column_reg <= column_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/slx_queue.sv -----
// Short request queue between the scanner front end and the output stage.
// Depends on slx_pkg for the entry type.
`default_nettype none

module slx_queue #(
    parameter int DEPTH = slx_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire slx_pkg::entry_t push_entry,
    input  wire logic            pop,
    output slx_pkg::entry_t      head,
    output logic                 full,
    output logic                 empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    slx_pkg::entry_t slots_reg [DEPTH];
    logic [IW-1:0]   wr_reg;
    logic [IW-1:0]   rd_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_reg] <= push_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- design/slx_back.sv -----
// Output stage: resolves keywords, splits an entry into its token requests
// and holds the output register. Depends on slx_pkg.
`default_nettype none

module slx_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire slx_pkg::entry_t head,
    input  wire logic            empty,
    output logic                 pop,
    input  wire logic            stall,
    output logic                 valid,
    output slx_pkg::token_item_t tok
);

    logic                 out_valid_reg;
    slx_pkg::token_item_t out_reg;
    logic                 second_reg;
    slx_pkg::token_item_t second_item_reg;
    logic                 load;
    slx_pkg::token_item_t first;
    slx_pkg::token_item_t eol_tok;

    assign load  = !out_valid_reg || !stall;
    assign pop   = load && !second_reg && !empty;
    assign valid = out_valid_reg;
    assign tok   = out_reg;

    // First request of the head entry, with identifiers checked against keywords
    always_comb
    begin
        first.token_class  = head.token_class;
        if ((head.token_class == slx_pkg::C_IDENT)
            && slx_pkg::keyword_hit(head.word, head.word_length))
            first.token_class = slx_pkg::C_KEYWORD;
        first.start_column = head.start_column;
        first.token_length = head.token_length;
        first.token_line   = head.token_line;
        first.last_of_run  = !head.eol_follows;

        eol_tok.token_class  = slx_pkg::C_EOL;
        eol_tok.start_column = head.eol_column;
        eol_tok.token_length = '0;
        eol_tok.token_line   = head.token_line;
        eol_tok.last_of_run  = 1'b1;
    end

    // Output register and the held second request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else if (load)
        begin
            if (second_reg)
            begin
                out_valid_reg <= 1'b1;
                second_reg    <= 1'b0;
            end
            else if (!empty)
            begin
                out_valid_reg <= 1'b1;
                second_reg    <= head.eol_follows;
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && second_reg)
            out_reg <= second_item_reg;
        else if (pop)
        begin
            out_reg         <= first;
            second_item_reg <= eol_tok;
        end
    end

endmodule

`default_nettype wire

// ----- design/source_line_lexer.sv -----
// Source line lexer: one character per cycle in while not stalled,
// token records out. A token is queued by the character that ends it,
// then loaded into the output register. An end of line closing a
// pending token yields two records, sent one per cycle unless stalled.
// Reset: asynchronous, active low; no clearing pass, ready at once.
// Depends on slx_pkg, slx_front, slx_queue and slx_back.
`default_nettype none

module source_line_lexer #(
    parameter int COLUMN_BITS = slx_pkg::COLUMN_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = slx_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 char_valid,
    output logic                      char_stall,
    input  wire slx_pkg::char_item_t  char_item,
    output logic                      tok_valid,
    input  wire logic                 tok_stall,
    output slx_pkg::token_item_t      tok_item,
    input  wire logic                 cfg_write,
    input  wire logic [15:0]          cfg_data
);

    logic            accept;
    logic            push;
    slx_pkg::entry_t entry;
    slx_pkg::entry_t head;
    logic            full;
    logic            empty;
    logic            pop;

    assign char_stall = full;
    assign accept     = char_valid && !full;

    slx_front #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (char_item),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .push      (push),
        .entry     (entry)
    );

    slx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    slx_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .stall (tok_stall),
        .valid (tok_valid),
        .tok   (tok_item)
    );

endmodule

`default_nettype wire
